// ===== rtl/ssas_pkg.sv =====
package ssas_pkg;

   localparam int ADDR_WIDTH = 5;
   localparam int DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      REG_HOLD_TICKS      = 3'd0,
      REG_END_SPEED       = 3'd1,
      REG_RAMP_STEP       = 3'd2,
      REG_CATCH_TIME      = 3'd3,
      REG_CATCH_MIN_SPEED = 3'd4,
      REG_ERROR_STEP      = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      SPIN_STILL   = 2'd0,
      SPIN_FORWARD = 2'd1,
      SPIN_REVERSE = 2'd2
   } spin_type;

   // classified input beat handed from front to back
   typedef struct packed {
      logic               is_start;
      logic               catch_request;
      logic               fwd;
      logic               rev;
      logic signed [15:0] theta;
   } op_type;

   typedef struct packed {
      logic [15:0] hold_ticks;
      logic [31:0] end_speed;
      logic [31:0] ramp_step;
      logic [15:0] catch_time;
      logic [14:0] error_step;
   } cfg_type;

endpackage

// ===== rtl/ssas_if.sv =====
interface ssas_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic               catch_request;
   logic signed [15:0] est_theta;
   logic signed [15:0] est_omega;

   modport source (output valid, cmd, catch_request, est_theta, est_omega, input ready);
   modport sink (input valid, cmd, catch_request, est_theta, est_omega, output ready);
endinterface

interface ssas_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] park_angle;
   logic               in_open_loop;
   logic               mode_changed;
   logic [1:0]         spin_status;
   logic               catch_busy;

   modport source (output valid, park_angle, in_open_loop, mode_changed, spin_status,
                   catch_busy, input ready);
   modport sink (input valid, park_angle, in_open_loop, mode_changed, spin_status,
                 catch_busy, output ready);
endinterface

// ===== rtl/sensorless_startup_angle_sequencer.sv =====
// Start-up angle sequencer for a sensorless PMSM drive: one request beat per control period
// (tick or start) returns exactly one response beat with the commutation angle and mode flags.
// Throughput is one beat per clock unless the response side stalls, limited by the state update
// in the back end (one 33-bit saturating ramp add feeding a 16-bit angle add). A beat accepted
// is written into the queue, and the back end registers its response beat from it; the queue
// holds QUEUE_DEPTH beats so request acceptance continues while a response waits. Registers sit
// on an APB port at 4*i; write them only in idle, which the block itself does not enforce.
module sensorless_startup_angle_sequencer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   ssas_req_if.sink                          req,
   ssas_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ssas_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [ssas_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [ssas_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                              pready
);
   import ssas_pkg::*;

   logic [15:0]   hold_ticks_ff;
   logic [31:0]   end_speed_ff;
   logic [31:0]   ramp_step_ff;
   logic [15:0]   catch_time_ff;
   logic [14:0]   catch_min_speed_ff;
   logic [14:0]   error_step_ff;
   reg_index_type reg_index;
   logic          csr_write;
   cfg_type       cfg;

   logic   front_valid, front_ready;
   op_type front_op;
   logic   back_valid, back_ready;
   op_type back_op;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff      <= '0;
         end_speed_ff       <= '0;
         ramp_step_ff       <= '0;
         catch_time_ff      <= '0;
         catch_min_speed_ff <= '0;
         error_step_ff      <= '0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_HOLD_TICKS:      hold_ticks_ff      <= pwdata[15:0];
            REG_END_SPEED:       end_speed_ff       <= pwdata;
            REG_RAMP_STEP:       ramp_step_ff       <= pwdata;
            REG_CATCH_TIME:      catch_time_ff      <= pwdata[15:0];
            REG_CATCH_MIN_SPEED: catch_min_speed_ff <= pwdata[14:0];
            REG_ERROR_STEP:      error_step_ff      <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_HOLD_TICKS:      prdata = {16'd0, hold_ticks_ff};
         REG_END_SPEED:       prdata = end_speed_ff;
         REG_RAMP_STEP:       prdata = ramp_step_ff;
         REG_CATCH_TIME:      prdata = {16'd0, catch_time_ff};
         REG_CATCH_MIN_SPEED: prdata = {17'd0, catch_min_speed_ff};
         REG_ERROR_STEP:      prdata = {17'd0, error_step_ff};
         default:             prdata = '0;
      endcase
   end

   assign cfg.hold_ticks = hold_ticks_ff;
   assign cfg.end_speed  = end_speed_ff;
   assign cfg.ramp_step  = ramp_step_ff;
   assign cfg.catch_time = catch_time_ff;
   assign cfg.error_step = error_step_ff;

   ssas_front u_front (
      .req             (req),
      .catch_min_speed (catch_min_speed_ff),
      .op_valid        (front_valid),
      .op_ready        (front_ready),
      .op              (front_op)
   );

   ssas_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_op),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_op)
   );

   ssas_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .op_valid (back_valid),
      .op_ready (back_ready),
      .op       (back_op),
      .rsp      (rsp)
   );

endmodule

// ===== rtl/ssas_front.sv =====
module ssas_front (
   ssas_req_if.sink         req,
   input  logic [14:0]      catch_min_speed,
   output logic             op_valid,
   input  logic             op_ready,
   output ssas_pkg::op_type op
);
   import ssas_pkg::*;

   logic signed [16:0] omega_ext;
   logic signed [16:0] min_ext;

   // speed classification against the catch threshold
   assign omega_ext = {req.est_omega[15], req.est_omega};
   assign min_ext   = $signed({2'b00, catch_min_speed});

   assign op.is_start      = req.cmd;
   assign op.catch_request = req.catch_request;
   assign op.fwd           = omega_ext > min_ext;
   assign op.rev           = omega_ext < -min_ext;
   assign op.theta         = req.est_theta;

   assign op_valid  = req.valid;
   assign req.ready = op_ready;

endmodule

// ===== rtl/ssas_queue.sv =====
module ssas_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ssas_pkg::op_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ssas_pkg::op_type pop_data
);
   import ssas_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/ssas_back.sv =====
module ssas_back (
   input  logic              clock,
   input  logic              reset,
   input  ssas_pkg::cfg_type cfg,
   input  logic              op_valid,
   output logic              op_ready,
   input  ssas_pkg::op_type  op,
   ssas_rsp_if.source        rsp
);
   import ssas_pkg::*;

   logic        open_ff, open_in;
   logic        catch_ff, catch_in;
   logic [15:0] catch_count_ff, catch_count_in;
   logic [15:0] lock_count_ff, lock_count_in;
   logic [31:0] ramp_acc_ff, ramp_acc_in;
   logic [15:0] angle_ff, angle_in;
   logic [15:0] error_ff, error_in;
   spin_type    spin_ff, spin_in;
   logic        changed;
   logic [32:0] ramp_sum;
   logic [16:0] err_ext, err_mag;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] park_angle_ff;
   logic               open_out_ff, changed_ff, catch_out_ff;
   logic [1:0]         spin_out_ff;
   logic               step;

   assign op_ready = !rsp_valid_ff || rsp.ready;
   assign step     = op_valid && op_ready;

   assign ramp_sum = {1'b0, ramp_acc_ff} + {1'b0, cfg.ramp_step};
   assign err_ext  = {error_ff[15], error_ff};
   assign err_mag  = err_ext[16] ? -err_ext : err_ext;

   always_comb begin
      open_in        = open_ff;
      catch_in       = catch_ff;
      catch_count_in = catch_count_ff;
      lock_count_in  = lock_count_ff;
      ramp_acc_in    = ramp_acc_ff;
      angle_in       = angle_ff;
      error_in       = error_ff;
      spin_in        = spin_ff;
      changed        = 1'b0;
      priority if (op.is_start) begin
         open_in        = 1'b1;
         catch_in       = op.catch_request;
         catch_count_in = '0;
         lock_count_in  = '0;
         ramp_acc_in    = '0;
      end else if (open_ff) begin
         if (catch_ff) begin
            if (catch_count_ff < cfg.catch_time) begin
               catch_count_in = catch_count_ff + 1'b1;
            end else begin
               catch_count_in = '0;
               catch_in       = 1'b0;
               priority if (op.fwd) begin
                  spin_in  = SPIN_FORWARD;
                  open_in  = 1'b0;
                  error_in = '0;
                  changed  = 1'b1;
               end else if (op.rev) begin
                  spin_in = SPIN_REVERSE;
               end else begin
                  spin_in = SPIN_STILL;
               end
            end
         end else begin
            priority if (lock_count_ff < cfg.hold_ticks) begin
               lock_count_in = lock_count_ff + 1'b1;
            end else if (ramp_acc_ff < cfg.end_speed) begin
               ramp_acc_in = ramp_sum[32] ? '1 : ramp_sum[31:0];
            end else begin
               open_in  = 1'b0;
               changed  = 1'b1;
               error_in = angle_ff - op.theta;
            end
            angle_in = angle_ff + ramp_acc_in[31:16];
         end
      end else begin
         angle_in = op.theta + error_ff;
         if (err_mag > {2'b00, cfg.error_step}) begin
            if (err_ext[16]) begin
               error_in = error_ff + {1'b0, cfg.error_step};
            end else begin
               error_in = error_ff - {1'b0, cfg.error_step};
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff        <= 1'b0;
         catch_ff       <= 1'b0;
         catch_count_ff <= '0;
         lock_count_ff  <= '0;
         ramp_acc_ff    <= '0;
         angle_ff       <= '0;
         error_ff       <= '0;
         spin_ff        <= SPIN_STILL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            open_ff        <= open_in;
            catch_ff       <= catch_in;
            catch_count_ff <= catch_count_in;
            lock_count_ff  <= lock_count_in;
            ramp_acc_ff    <= ramp_acc_in;
            angle_ff       <= angle_in;
            error_ff       <= error_in;
            spin_ff        <= spin_in;
         end
      end
   end

   // result register, no reset on payload
   always_ff @(posedge clock) begin
      if (step) begin
         park_angle_ff <= angle_in;
         open_out_ff   <= open_in;
         changed_ff    <= changed;
         spin_out_ff   <= spin_in;
         catch_out_ff  <= catch_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.park_angle   = park_angle_ff;
   assign rsp.in_open_loop = open_out_ff;
   assign rsp.mode_changed = changed_ff;
   assign rsp.spin_status  = spin_out_ff;
   assign rsp.catch_busy   = catch_out_ff;

endmodule

// ===== rtl/ssas_checker.sv =====
module ssas_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_park_angle,
   input logic        rsp_in_open_loop,
   input logic        rsp_mode_changed,
   input logic [1:0]  rsp_spin_status,
   input logic        rsp_catch_busy
);
   import ssas_pkg::*;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_park_angle)
                                  && $stable(rsp_mode_changed))
      else $error("response beat changed while stalled");

   // handover beat leaves open loop
   a_change_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_changed |-> !rsp_in_open_loop)
      else $error("mode change reported while still in open loop");

   // catch window only runs in open loop
   a_catch_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_catch_busy |-> rsp_in_open_loop && !rsp_mode_changed)
      else $error("catch window busy outside open loop");

   // spin status is always one of the defined codes
   a_spin_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_spin_status == SPIN_STILL || rsp_spin_status == SPIN_FORWARD
                    || rsp_spin_status == SPIN_REVERSE)
      else $error("invalid spin status");

endmodule

bind sensorless_startup_angle_sequencer ssas_checker u_ssas_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_park_angle   (rsp.park_angle),
   .rsp_in_open_loop (rsp.in_open_loop),
   .rsp_mode_changed (rsp.mode_changed),
   .rsp_spin_status  (rsp.spin_status),
   .rsp_catch_busy   (rsp.catch_busy)
);
